// ----- hdl/j2oa_pkg.sv -----
// ----------------------------------------------------------------------------
// j2oa_pkg
// Shared constants, stage types and rounding helper for the J2 oblateness
// acceleration pipeline.
// ----------------------------------------------------------------------------
package j2oa_pkg;

  localparam int unsigned BODY_COUNT = 16;
  localparam int unsigned IDX_W      = 4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Remainder holds 2*N with N below 2^166, divisor is r^4 below 2^128.
  localparam int unsigned REM_W = 168;
  localparam int unsigned DEN_W = 128;
  // Quotient bits of floor(2N/D); anything at or above 2^QW saturates.
  localparam int unsigned QW    = 49;
  localparam int unsigned CMP_W = DEN_W + QW;
  localparam int unsigned ACC_W = 48;

  typedef struct packed {
    logic                        vld;
    logic                        zero;
    logic                        dz;
    logic [2:0]                  neg;
    logic [2:0]                  nz;
    logic [2:0]                  big;
    logic [2:0][REM_W-1:0]       rem;
    logic [2:0][QW-1:0]          q;
    logic [DEN_W-1:0]            den;
  } div_t;

  // Round x / 2^30 half away from zero.
  function automatic logic signed [36:0] rnd30(input logic signed [65:0] x);
    logic [65:0] mag;
    logic [65:0] r;
    mag = x[65] ? 66'(-x) : 66'(x);
    r   = (mag + (66'(1) << 29)) >> 30;
    rnd30 = x[65] ? -$signed(37'(r)) : $signed(37'(r));
  endfunction

endpackage

// ----- hdl/j2_oblateness_acceleration.sv -----
// ----------------------------------------------------------------------------
// j2_oblateness_acceleration
// Body table plus a fully pipelined J2 zonal perturbation evaluator with a
// restoring divider of one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid / in_ready     | op, body index, body data, direction, dist
//  out     | out_valid / out_ready   | accel x/y/z (Q16.32), saturated flag
//
//  One beat is accepted per cycle while the output is not held; a compute
//  beat passes ten arithmetic stages, one range check, 49 divider stages and
//  the output register. The divider chain sets the latency.
//  Load beats update the table at acceptance and leave a bubble behind.
//  Reset clears only the valid bits; the table is undefined until loaded.
//  When the output is held, the whole pipeline holds with it.
// ----------------------------------------------------------------------------
module j2_oblateness_acceleration
  import j2oa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [IDX_W-1:0]        in_body_index,
  input  logic [31:0]             in_j2_coef,
  input  logic [31:0]             in_grav_param,
  input  logic [31:0]             in_eq_radius,
  input  logic signed [31:0]      in_axis_x,
  input  logic signed [31:0]      in_axis_y,
  input  logic signed [31:0]      in_axis_z,
  input  logic signed [31:0]      in_dir_x,
  input  logic signed [31:0]      in_dir_y,
  input  logic signed [31:0]      in_dir_z,
  input  logic [31:0]             in_dist_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_accel_x,
  output logic signed [ACC_W-1:0] out_accel_y,
  output logic signed [ACC_W-1:0] out_accel_z,
  output logic                    out_saturated
);

  logic en, in_fire, in_range;

  logic [31:0]        j2_tbl_r   [BODY_COUNT];
  logic [31:0]        gm_tbl_r   [BODY_COUNT];
  logic [31:0]        rad_tbl_r  [BODY_COUNT];
  logic signed [31:0] pole_tbl_r [BODY_COUNT][3];

  logic [10:1] fv_r, zf_r, dzf_r;

  logic signed [31:0] d_r [1:5][3];
  logic signed [31:0] k_r [1:5][3];
  logic [31:0]        j1_r, g1_r, rad1_r, dist1_r;
  logic signed [63:0] p2_r [3];
  logic [63:0]        r2_r, rr2_r, jg2_r;
  logic signed [31:0] u3_r, u_nxt;
  logic [63:0]        aa3_r, ab3_r, bb3_r, ac3_r, ae3_r, bc3_r, be3_r;
  logic [63:0]        uu4_r;
  logic signed [32:0] t_r [4:5];
  logic [DEN_W-1:0]   den_r [4:10];
  logic [127:0]       kk_r [4:8];
  logic signed [33:0] s5_r, s_nxt;
  logic signed [65:0] ps6_r [3];
  logic signed [65:0] pt6_r [3];
  logic signed [36:0] v7_r [3];
  logic [2:0]         neg_r [8:10];
  logic [37:0]        w8_r [3];
  logic [69:0]        pp9_r [3][4];
  logic [REM_W-1:0]   num10_r [3];

  div_t dv_r [0:QW];
  div_t dv0_nxt;

  logic                    out_valid_r, out_sat_r, out_sat_nxt;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && en;
  assign in_range = {{(32-IDX_W){1'b0}}, in_body_index} < BODY_COUNT;

  // Table writes land at acceptance, so a compute beat right behind a load
  // of the same body already sees the new entry.
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_LOAD && in_range) begin
      j2_tbl_r[in_body_index]      <= in_j2_coef;
      gm_tbl_r[in_body_index]      <= in_grav_param;
      rad_tbl_r[in_body_index]     <= in_eq_radius;
      pole_tbl_r[in_body_index][0] <= in_axis_x;
      pole_tbl_r[in_body_index][1] <= in_axis_y;
      pole_tbl_r[in_body_index][2] <= in_axis_z;
    end
  end

  always_comb begin
    logic signed [36:0] usum;
    usum = rnd30(66'(p2_r[0])) + rnd30(66'(p2_r[1])) + rnd30(66'(p2_r[2]));
    if (usum > 37'sd1073741824) begin
      u_nxt = 32'sd1073741824;
    end else if (usum < -37'sd1073741824) begin
      u_nxt = -32'sd1073741824;
    end else begin
      u_nxt = 32'(usum);
    end
  end

  always_comb begin
    logic [63:0] u2;
    u2    = (uu4_r + (64'(1) << 29)) >> 30;
    s_nxt = $signed(34'(1) << 30) - $signed(34'(u2) * 34'd5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[9:1], in_fire && in_op == OP_COMPUTE};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r  <= {zf_r[9:1], !in_range || j2_tbl_r[in_body_index] == 32'd0};
      dzf_r <= {dzf_r[9:1], in_dist_req == 32'd0};
      // Stage 1: capture the beat and its table entry.
      d_r[1][0] <= in_dir_x;
      d_r[1][1] <= in_dir_y;
      d_r[1][2] <= in_dir_z;
      for (int c = 0; c < 3; c++) k_r[1][c] <= pole_tbl_r[in_body_index][c];
      j1_r    <= j2_tbl_r[in_body_index];
      g1_r    <= gm_tbl_r[in_body_index];
      rad1_r  <= rad_tbl_r[in_body_index];
      dist1_r <= in_dist_req;
      for (int s = 2; s <= 5; s++) begin
        d_r[s] <= d_r[s-1];
        k_r[s] <= k_r[s-1];
      end
      // Stage 2: first-level products.
      for (int c = 0; c < 3; c++) p2_r[c] <= 64'(d_r[1][c]) * 64'(k_r[1][c]);
      r2_r  <= 64'(dist1_r) * 64'(dist1_r);
      rr2_r <= 64'(rad1_r) * 64'(rad1_r);
      jg2_r <= 64'(j1_r) * 64'(g1_r);
      // Stage 3: u and the 64x64 partial products.
      u3_r  <= u_nxt;
      aa3_r <= 64'(r2_r[63:32]) * 64'(r2_r[63:32]);
      ab3_r <= 64'(r2_r[63:32]) * 64'(r2_r[31:0]);
      bb3_r <= 64'(r2_r[31:0]) * 64'(r2_r[31:0]);
      ac3_r <= 64'(jg2_r[63:32]) * 64'(rr2_r[63:32]);
      ae3_r <= 64'(jg2_r[63:32]) * 64'(rr2_r[31:0]);
      bc3_r <= 64'(jg2_r[31:0]) * 64'(rr2_r[63:32]);
      be3_r <= 64'(jg2_r[31:0]) * 64'(rr2_r[31:0]);
      // Stage 4: u squared, r^4 and J2*GM*R^2 assembled.
      uu4_r    <= 64'(u3_r * u3_r);
      t_r[4]   <= $signed({u3_r, 1'b0});
      den_r[4] <= {aa3_r, 64'd0} + {31'd0, ab3_r, 33'd0} + {64'd0, bb3_r};
      kk_r[4]  <= {ac3_r, 64'd0} + {32'd0, ae3_r, 32'd0} + {32'd0, bc3_r, 32'd0}
                  + {64'd0, be3_r};
      for (int s = 5; s <= 10; s++) den_r[s] <= den_r[s-1];
      for (int s = 5; s <= 8; s++) kk_r[s] <= kk_r[s-1];
      // Stage 5: s = 1 - 5u^2.
      s5_r   <= s_nxt;
      t_r[5] <= t_r[4];
      // Stage 6: s*d and 2u*k.
      for (int c = 0; c < 3; c++) begin
        ps6_r[c] <= 66'(s5_r) * 66'(d_r[5][c]);
        pt6_r[c] <= 66'(t_r[5]) * 66'(k_r[5][c]);
      end
      // Stage 7: bracket vector.
      for (int c = 0; c < 3; c++) v7_r[c] <= rnd30(ps6_r[c]) + rnd30(pt6_r[c]);
      // Stage 8: sign and 6*|V|.
      for (int c = 0; c < 3; c++) begin
        neg_r[8][c] <= !v7_r[c][36] && v7_r[c] != 37'sd0;
        w8_r[c]     <= 38'(v7_r[c][36] ? 37'(-v7_r[c]) : 37'(v7_r[c])) * 38'd6;
      end
      neg_r[9]  <= neg_r[8];
      neg_r[10] <= neg_r[9];
      // Stage 9: limb products of the numerator.
      for (int c = 0; c < 3; c++) begin
        for (int l = 0; l < 4; l++) begin
          pp9_r[c][l] <= 70'(kk_r[8][32*l +: 32]) * 70'(w8_r[c]);
        end
      end
      // Stage 10: numerator sums.
      for (int c = 0; c < 3; c++) begin
        num10_r[c] <= REM_W'(pp9_r[c][0]) + (REM_W'(pp9_r[c][1]) << 32)
                      + (REM_W'(pp9_r[c][2]) << 64) + (REM_W'(pp9_r[c][3]) << 96);
      end
    end
  end

  // Stage 11: double the numerator and flag quotients that cannot fit.
  always_comb begin
    dv0_nxt      = '0;
    dv0_nxt.vld  = fv_r[10];
    dv0_nxt.zero = zf_r[10];
    dv0_nxt.dz   = dzf_r[10];
    dv0_nxt.neg  = neg_r[10];
    dv0_nxt.den  = den_r[10];
    for (int c = 0; c < 3; c++) begin
      dv0_nxt.rem[c] = {num10_r[c][REM_W-2:0], 1'b0};
      dv0_nxt.nz[c]  = num10_r[c] != '0;
      dv0_nxt.big[c] = {{(CMP_W-REM_W){1'b0}}, num10_r[c][REM_W-2:0], 1'b0}
                       >= {den_r[10], {QW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].vld <= 1'b0;
    end else if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int unsigned B = QW - 1 - g;
    div_t div_nxt;

    always_comb begin
      logic [CMP_W-1:0] ext;
      logic [CMP_W-1:0] sh;
      div_nxt = dv_r[g];
      sh      = {{QW{1'b0}}, dv_r[g].den} << B;
      for (int c = 0; c < 3; c++) begin
        ext = {{(CMP_W-REM_W){1'b0}}, dv_r[g].rem[c]};
        if (ext >= sh) begin
          div_nxt.rem[c]    = REM_W'(ext - sh);
          div_nxt.q[c][B]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g+1].vld <= 1'b0;
      end else if (en) begin
        dv_r[g+1] <= div_nxt;
      end
    end
  end

  // Output stage: round, clip and apply the sign of -V.
  always_comb begin
    logic [QW:0] qr;
    logic [QW:0] lim;
    logic [QW:0] m;
    logic        clip;
    out_sat_nxt = dv_r[QW].dz;
    for (int c = 0; c < 3; c++) begin
      qr   = ({1'b0, dv_r[QW].q[c]} + (QW+1)'(1)) >> 1;
      lim  = dv_r[QW].neg[c] ? ((QW+1)'(1) << (ACC_W-1))
                             : ((QW+1)'(1) << (ACC_W-1)) - (QW+1)'(1);
      clip = dv_r[QW].big[c] || qr > lim;
      m    = clip ? lim : qr;
      if (!dv_r[QW].nz[c]) begin
        acc_nxt[c] = '0;
      end else begin
        acc_nxt[c] = dv_r[QW].neg[c] ? $signed(ACC_W'((QW+1)'(0) - m))
                                     : $signed(ACC_W'(m));
        if (clip) out_sat_nxt = 1'b1;
      end
    end
    if (dv_r[QW].zero) begin
      for (int c = 0; c < 3; c++) acc_nxt[c] = '0;
      out_sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sat_r <= out_sat_nxt;
      for (int c = 0; c < 3; c++) acc_r[c] <= acc_nxt[c];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accel_x   = acc_r[0];
  assign out_accel_y   = acc_r[1];
  assign out_accel_z   = acc_r[2];
  assign out_saturated = out_sat_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_LOAD |=> !fv_r[1])
    else $error("load beat entered the compute pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(fv_r))
    else $error("pipeline moved during a stall");

  a_zero_dist_flag: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv_r[QW].vld && dv_r[QW].dz && !dv_r[QW].zero |=> out_saturated)
    else $error("zero distance result not flagged");

endmodule
